### hdl/kmp_pkg.sv
// Package with shared constants and input-kind codes of the KMP stream matcher.
package kmp_pkg;

  // Default capacity of the pattern store
  localparam int unsigned MaxPatternDef = 64;

  // Width of a pattern or text byte
  localparam int unsigned ChW = 8;

  // Width of the text position counter
  localparam int unsigned PosW = 32;

  // Kind of an input request, carried in tuser
  typedef enum logic {
    MODE_PATTERN = 1'b0,
    MODE_TEXT    = 1'b1
  } mode_e;

endpackage

### hdl/kmp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module kmp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry and register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/kmp_stream_matcher_core.sv
// Top level of the KMP stream matcher: sequencer, pattern store and failure-link store.
//
// Input stream (s_axis): tuser selects the request kind (0 = pattern byte, 1 = text byte);
// tdata carries the byte and a "first" flag that starts a new pattern or a new text.
// Pattern bytes build the failure table incrementally; text bytes are searched against it.
// Output stream (m_axis): exactly one result per request, carrying found, the 1-based
// start position of a completed match, and a flag for a pattern byte dropped on a full store.
// Sequencing: one request is worked at a time. A compare step reads the pattern byte
// and the failure link from their RAMs (registered read, StRead) and then decides
// (StCmp), so each candidate prefix tried passes through both states. A text byte takes
// one compare step per link followed plus one, and on a full match StFwait fetches the
// fallback link. A pattern byte first fetches its starting link in StLwait; the first
// pattern byte, a dropped pattern byte, and a text byte against an empty pattern finish
// in StIdle. The shared comparator and the single read port of each RAM set this order.
// Reset: the pattern is empty, no prefix is matched and the text position is zero; the
// stores need no clearing pass since only written entries are ever read.
// Stall: a result waits in the output register; a new request is taken once it is
// taken or leaves in the same cycle. The text position saturates at its maximum.
module kmp_stream_matcher_core
  import kmp_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MaxPatternDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] ch, [8] first, [15:9] zero
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [0] found, [32:1] match_start,
                                      // [33] pattern_overflow, [39:34] zero
);

  // Index and length widths
  localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned IW = $clog2(MAX_PATTERN + 1);
  localparam logic [IW-1:0] MaxLen = IW'(MAX_PATTERN);
  localparam logic [PosW-1:0] PosMax = '1;

  // Sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLwait = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StCmp   = 3'd3;
  localparam logic [2:0] StFwait = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [IW-1:0]   len_q, len_d;
  logic [IW-1:0]   prefix_q, prefix_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [IW-1:0]   s_q, s_d;
  logic [ChW-1:0]  ch_q, ch_d;
  logic            mode_q, mode_d;

  logic            out_valid_q, out_valid_d;
  logic            out_found_q, out_found_d;
  logic [PosW-1:0] out_start_q, out_start_d;
  logic            out_ovf_q, out_ovf_d;

  logic            p_we;
  logic [AW-1:0]   p_waddr, p_raddr;
  logic [ChW-1:0]  p_rdata;
  logic            l_we;
  logic [AW-1:0]   l_waddr, l_wdata, l_raddr;
  logic [AW-1:0]   l_rdata;

  logic            in_acc;
  logic [ChW-1:0]  in_ch;
  logic            in_first;
  logic            in_mode;
  logic            res_vld;
  logic            cmp_eq;
  logic [IW-1:0]   s_inc;
  logic [IW-1:0]   n_acc;
  logic [IW-1:0]   s_start;
  logic [IW-1:0]   s_fin;
  logic [PosW-1:0] pos_inc;
  logic [PosW-1:0] len_ext;

  assign in_ch    = s_axis_tdata[7:0];
  assign in_first = s_axis_tdata[8];
  assign in_mode  = s_axis_tuser;

  assign s_axis_tready = (state_q == StIdle) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_ovf_q, out_start_q, out_found_q};

  // Shared compare and step values
  assign cmp_eq  = (p_rdata == ch_q);
  assign s_inc   = s_q + IW'(1);
  assign s_fin   = cmp_eq ? s_inc : s_q;
  assign n_acc   = in_first ? '0 : len_q;
  assign s_start = (in_first || (prefix_q >= len_q)) ? '0 : prefix_q;
  assign pos_inc = in_first ? PosW'(1) : ((pos_q == PosMax) ? pos_q : pos_q + PosW'(1));
  assign len_ext = PosW'(len_q);

  // Read addresses: candidate byte and its link while stepping, else the last link
  assign p_raddr = s_q[AW-1:0];
  assign l_raddr = (state_q == StRead) ? AW'(s_q - IW'(1)) : AW'(len_q - IW'(1));

  // Store each pattern byte as it is accepted, unless the store is full
  assign p_we    = in_acc && (in_mode == MODE_PATTERN) && (n_acc < MaxLen);
  assign p_waddr = n_acc[AW-1:0];

  // Sequence one request
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    prefix_d    = prefix_q;
    pos_d       = pos_q;
    s_d         = s_q;
    ch_d        = ch_q;
    mode_d      = mode_q;
    res_vld     = 1'b0;
    out_found_d = 1'b0;
    out_start_d = '0;
    out_ovf_d   = 1'b0;
    l_we        = 1'b0;
    l_waddr     = '0;
    l_wdata     = '0;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          ch_d   = in_ch;
          mode_d = in_mode;
          if (in_mode == MODE_PATTERN) begin
            if (in_first) begin
              prefix_d = '0;
              pos_d    = '0;
            end
            if (n_acc >= MaxLen) begin
              res_vld   = 1'b1;
              out_ovf_d = 1'b1;
            end else if (n_acc == '0) begin
              l_we    = 1'b1;
              len_d   = IW'(1);
              res_vld = 1'b1;
            end else begin
              state_d = StLwait;
            end
          end else begin
            pos_d = pos_inc;
            if (in_first) begin
              prefix_d = '0;
            end
            if (len_q == '0) begin
              res_vld = 1'b1;
            end else begin
              s_d     = s_start;
              state_d = StRead;
            end
          end
        end
      end
      StLwait: begin
        s_d     = IW'(l_rdata);
        state_d = StRead;
      end
      StRead: begin
        state_d = StCmp;
      end
      StCmp: begin
        if (!cmp_eq && (s_q != '0)) begin
          // Follow the failure link and try again
          s_d     = IW'(l_rdata);
          state_d = StRead;
        end else if (mode_q == MODE_PATTERN) begin
          l_we    = 1'b1;
          l_waddr = len_q[AW-1:0];
          l_wdata = s_fin[AW-1:0];
          len_d   = len_q + IW'(1);
          res_vld = 1'b1;
          state_d = StIdle;
        end else if (s_fin == len_q) begin
          // Full match: fetch the fallback link
          state_d = StFwait;
        end else begin
          prefix_d = s_fin;
          res_vld  = 1'b1;
          state_d  = StIdle;
        end
      end
      StFwait: begin
        prefix_d    = IW'(l_rdata);
        res_vld     = 1'b1;
        out_found_d = 1'b1;
        out_start_d = (pos_q >= len_ext) ? (pos_q - len_ext + PosW'(1)) : PosW'(1);
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold a result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res_vld) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      prefix_q    <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      prefix_q    <= prefix_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    ch_q   <= ch_d;
    mode_q <= mode_d;
    if (res_vld) begin
      out_found_q <= out_found_d;
      out_start_q <= out_start_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  // Pattern byte store
  kmp_ram #(
    .WIDTH (ChW),
    .DEPTH (MAX_PATTERN)
  ) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (in_ch),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // Failure-link store, each entry holding link plus one
  kmp_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_PATTERN)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

endmodule

### bench/tb_kmp_stream_matcher_core.sv
// Self-checking testbench for the KMP stream matcher core with a cycle-free match predictor.
`timescale 1ns / 100ps

module tb_kmp_stream_matcher_core;
  import kmp_pkg::*;

  localparam int unsigned MAX_PATTERN = MaxPatternDef;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic        found;
    logic [31:0] start;
    logic        overflow;
  } match_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [7:0] ch, [8] first, [15:9] zero
  logic        s_axis_tuser = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [0] found, [32:1] match_start,
                                    // [33] pattern_overflow, [39:34] zero

  // Predictor state: pattern, failure links, matched prefix, text position
  logic [7:0]  pat_bytes [MAX_PATTERN];
  int          pat_links [MAX_PATTERN];
  int          pat_len = 0;
  int          prefix_k = -1;
  logic [31:0] text_pos = '0;

  match_result_t pending_results [$];
  int            mismatch_count = 0;
  int            items_sent = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;

  kmp_stream_matcher_core #(
    .MAX_PATTERN (MAX_PATTERN)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Generate the 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Work out the result of one request and advance the predictor state
  function automatic match_result_t predict_match(input mode_e mode, input logic [7:0] ch,
                                                  input logic first);
    match_result_t res;
    int n;
    int k;
    res = '0;
    if (mode == MODE_PATTERN) begin
      if (first) begin
        pat_len = 0;
        prefix_k = -1;
        text_pos = '0;
      end
      n = pat_len;
      if (n >= MAX_PATTERN) begin
        res.overflow = 1'b1;
      end else begin
        pat_bytes[n] = ch;
        if (n == 0) begin
          pat_links[0] = -1;
        end else begin
          // Extend the prefix function by one byte
          k = pat_links[n-1];
          while (k >= 0 && pat_bytes[k+1] != ch) k = pat_links[k];
          if (pat_bytes[k+1] == ch) k++;
          pat_links[n] = k;
        end
        pat_len = n + 1;
      end
    end else begin
      if (first) begin
        prefix_k = -1;
        text_pos = '0;
      end
      if (text_pos != '1) text_pos++;
      n = pat_len;
      if (n > 0) begin
        k = prefix_k;
        if (k > n - 2) k = -1;
        while (k >= 0 && pat_bytes[k+1] != ch) k = pat_links[k];
        if (pat_bytes[k+1] == ch) k++;
        // Report a full match and fall back for overlapping ones
        if (k == n - 1) begin
          res.found = 1'b1;
          res.start = (text_pos >= 32'(n)) ? text_pos - 32'(n) + 32'd1 : 32'd1;
          k = pat_links[k];
        end
        prefix_k = k;
      end
    end
    return res;
  endfunction

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    match_result_t want;
    match_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found    = m_axis_tdata[0];
      got.start    = m_axis_tdata[32:1];
      got.overflow = m_axis_tdata[33];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: found=%0b start=%0d overflow=%0b",
                   got.found, got.start, got.overflow);
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found || got.start !== want.start ||
            got.overflow !== want.overflow) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: expected found=%0b start=%0d overflow=%0b",
                     $realtime, want.found, want.start, want.overflow);
            $display("  got found=%0b start=%0d overflow=%0b",
                     got.found, got.start, got.overflow);
          end
        end
      end
    end
  end

  // Offer one request, idling first at random, and record its expected result
  task automatic send_request(input mode_e mode, input logic [7:0] ch, input logic first);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {7'd0, first, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_match(mode, ch, first));
    items_sent++;
  endtask

  // Hold off new requests until every expected result has come
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
  endtask

  // Empty pattern, field extremes, overlapping matches, pattern grown mid-text
  task automatic test_directed();
    send_request(MODE_TEXT, 8'h00, 1'b1);
    send_request(MODE_TEXT, 8'hFF, 1'b0);
    send_request(MODE_PATTERN, 8'hFF, 1'b1);
    send_request(MODE_PATTERN, 8'h00, 1'b0);
    send_request(MODE_PATTERN, 8'hFF, 1'b0);
    send_request(MODE_TEXT, 8'hFF, 1'b1);
    send_request(MODE_TEXT, 8'h00, 1'b0);
    send_request(MODE_TEXT, 8'hFF, 1'b0);
    send_request(MODE_TEXT, 8'h00, 1'b0);
    send_request(MODE_TEXT, 8'hFF, 1'b0);
    send_request(MODE_TEXT, 8'h00, 1'b0);
    send_request(MODE_PATTERN, 8'h00, 1'b0);
    send_request(MODE_TEXT, 8'hFF, 1'b0);
    send_request(MODE_TEXT, 8'h00, 1'b0);
    send_request(MODE_TEXT, 8'hFF, 1'b1);
    send_request(MODE_TEXT, 8'h00, 1'b0);
    send_request(MODE_PATTERN, 8'h5A, 1'b1);
    send_request(MODE_TEXT, 8'h5A, 1'b1);
    send_request(MODE_TEXT, 8'h5A, 1'b0);
    send_request(MODE_TEXT, 8'hA5, 1'b0);
    send_request(MODE_TEXT, 8'h5A, 1'b0);
  endtask

  // Fill the pattern store past capacity, then search for the full pattern
  task automatic test_store_full();
    logic [7:0] sym [2];
    logic [7:0] pat_copy [$];
    int i;
    sym[0] = 8'($urandom);
    sym[1] = 8'($urandom);
    for (i = 0; i < MAX_PATTERN + 3; i++) begin
      pat_copy.push_back(sym[$urandom_range(1)]);
      send_request(MODE_PATTERN, pat_copy[i], i == 0);
    end
    for (i = 0; i < MAX_PATTERN; i++) send_request(MODE_TEXT, pat_copy[i], i == 0);
    for (i = 0; i < 8; i++) send_request(MODE_TEXT, sym[$urandom_range(1)], 1'b0);
  endtask

  // Random short patterns over small alphabets with texts rich in matches
  task automatic test_random_streams(input int n_items);
    logic [7:0] alpha [3];
    logic [7:0] pat_copy [$];
    logic       text_first;
    int         asz;
    int         plen;
    int         tlen;
    int         stop_at;
    int         i;
    int         j;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      for (i = 0; i < 3; i++) alpha[i] = 8'($urandom);
      asz = $urandom_range(1, 3);
      plen = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      pat_copy.delete();
      for (i = 0; i < plen; i++) begin
        pat_copy.push_back(alpha[$urandom_range(asz - 1)]);
        send_request(MODE_PATTERN, pat_copy[i], i == 0);
      end
      // Mostly restart the text, sometimes continue the old position
      text_first = ($urandom_range(3) != 0);
      tlen = $urandom_range(8, 30);
      i = 0;
      while (i < tlen) begin
        case ($urandom_range(9))
          0: begin
            send_request(mode_e'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)));
            i++;
          end
          1: begin
            pat_copy.push_back(alpha[$urandom_range(asz - 1)]);
            send_request(MODE_PATTERN, pat_copy[pat_copy.size() - 1], 1'b0);
          end
          2, 3, 4: begin
            for (j = 0; j < pat_copy.size(); j++) begin
              send_request(MODE_TEXT, pat_copy[j], text_first);
              text_first = 1'b0;
            end
            i += pat_copy.size();
          end
          default: begin
            send_request(MODE_TEXT, alpha[$urandom_range(asz - 1)], text_first);
            text_first = 1'b0;
            i++;
          end
        endcase
      end
    end
  endtask

  // Run the tests in turn under three idling settings
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 36;
    recv_idle_pct = 81;
    test_directed();
    test_store_full();
    test_random_streams(70);
    wait_for_results();
    send_idle_pct = 81;
    recv_idle_pct = 36;
    test_random_streams(70);
    wait_for_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_streams(70);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_kmp_stream_matcher_core: PASS");
    end else begin
      $display("tb_kmp_stream_matcher_core: FAIL");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #8000000;
    $display("tb_kmp_stream_matcher_core: FAIL");
    $finish;
  end

endmodule
